>>> rtl/f2h_pkg.sv
// f2h_pkg: shared types and constants for the single-to-half converter.
// Used by float32_to_float16_convert; depends on nothing else.
package f2h_pkg;

  // Exponent bias difference between single and half (127 - 15)
  localparam logic [7:0] EXP_OFFSET   = 8'd112;
  // Single exponent at or above which the half result overflows (112 + 31)
  localparam logic [7:0] EXP_OVF      = 8'd143;
  // Single exponent below which even a subnormal half flushes to zero (112 - 10)
  localparam logic [7:0] EXP_FLUSH    = 8'd102;
  // Subnormal shift base: shift = 14 + 112 - exp
  localparam logic [7:0] SUB_SHIFT_BASE = 8'd126;
  localparam logic [7:0] SGL_EXP_MAX  = 8'hFF;
  localparam logic [4:0] HLF_EXP_MAX  = 5'h1F;
  localparam logic [9:0] HLF_QNAN_MANT = 10'h200;

  // Result class decided from the input exponent and mantissa
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_INF,
    CLS_NAN,
    CLS_SUB,
    CLS_NORM
  } f2h_class_t;

  // Stage 1 payload: decoded fields
  typedef struct packed {
    logic        sign;
    f2h_class_t  cls;
    logic [7:0]  exp;
    logic [22:0] man;
    logic [4:0]  sub_shift;
  } f2h_dec_t;

  // Stage 2 payload: aligned mantissa and round decision
  typedef struct packed {
    logic        sign;
    f2h_class_t  cls;
    logic [4:0]  hexp;
    logic [9:0]  hman;
    logic        round_up;
  } f2h_aln_t;

endpackage

>>> rtl/float32_to_float16_convert.sv
// float32_to_float16_convert: binary32 to binary16 converter, three-stage pipeline.
// Depends on f2h_pkg for the class enum, stage payload structs and constants.
//
//   channel | direction | ports                                  | width
//   in      | input     | in_valid, in_stall(out), in_single_bits | 32
//   out     | output    | out_valid, out_stall(in), out_half_bits | 16
//
// An item passes three register stages, s1_r, s2_r and s3_r, and out_valid is
// driven from the last; one item enters every cycle while in_stall is low.
// Stage 1 decodes and classifies, stage 2 aligns and decides rounding,
// stage 3 adds the round increment and assembles the result into the output
// register. Reset (rst_n low, synchronous) clears the stage valid bits only.
// A stalled output holds; empty stages ahead of it keep filling, so in_stall
// rises only once every stage holds an item.
module float32_to_float16_convert
  import f2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_single_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_half_bits
);

  logic       v1_r, v2_r, v3_r;
  logic       v1_nxt, v2_nxt, v3_nxt;
  logic       rdy1, rdy2, rdy3;
  f2h_dec_t   s1_r, s1_nxt;
  f2h_aln_t   s2_r, s2_nxt;
  logic [15:0] s3_r, s3_nxt;

  // Per-stage advance: a stage loads when it is empty or its successor loads
  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r     : v2_r;
  assign v3_nxt = rdy3 ? v2_r     : v3_r;

  // Stage 1: split fields and classify
  logic [7:0] in_exp;
  logic [22:0] in_man;
  logic [7:0] shift_full;
  assign in_exp     = in_single_bits[30:23];
  assign in_man     = in_single_bits[22:0];
  assign shift_full = SUB_SHIFT_BASE - in_exp;

  always_comb begin
    s1_nxt.sign      = in_single_bits[31];
    s1_nxt.exp       = in_exp;
    s1_nxt.man       = in_man;
    s1_nxt.sub_shift = shift_full[4:0];
    priority if (in_exp == SGL_EXP_MAX) begin
      s1_nxt.cls = (in_man != 23'd0) ? CLS_NAN : CLS_INF;
    end else if (in_exp == 8'd0) begin
      s1_nxt.cls = CLS_ZERO;
    end else if (in_exp >= EXP_OVF) begin
      s1_nxt.cls = CLS_INF;
    end else if (in_exp < EXP_FLUSH) begin
      s1_nxt.cls = CLS_ZERO;
    end else if (in_exp <= EXP_OFFSET) begin
      s1_nxt.cls = CLS_SUB;
    end else begin
      s1_nxt.cls = CLS_NORM;
    end
  end

  // Stage 2: subnormal alignment, normal truncation and round decision
  logic [23:0] sub_aligned;
  logic [7:0]  hexp_full;
  assign sub_aligned = {1'b1, s1_r.man} >> s1_r.sub_shift;
  assign hexp_full   = s1_r.exp - EXP_OFFSET;

  always_comb begin
    s2_nxt.sign     = s1_r.sign;
    s2_nxt.cls      = s1_r.cls;
    s2_nxt.hexp     = hexp_full[4:0];
    s2_nxt.round_up = 1'b0;
    if (s1_r.cls == CLS_SUB) begin
      s2_nxt.hman = sub_aligned[9:0];
    end else begin
      s2_nxt.hman = s1_r.man[22:13];
      // Round bit set and either sticky bits or odd LSB: round to nearest even
      s2_nxt.round_up = s1_r.man[12] && ((s1_r.man[11:0] != 12'd0) || s1_r.man[13]);
    end
  end

  // Stage 3: apply increment, carry into exponent, assemble
  logic [10:0] man_inc;
  logic [4:0]  exp_inc;
  assign man_inc = {1'b0, s2_r.hman} + {10'd0, s2_r.round_up};
  assign exp_inc = s2_r.hexp + 5'd1;

  always_comb begin
    unique case (s2_r.cls)
      CLS_ZERO: s3_nxt = {s2_r.sign, 15'd0};
      CLS_INF:  s3_nxt = {s2_r.sign, HLF_EXP_MAX, 10'd0};
      CLS_NAN:  s3_nxt = {s2_r.sign, HLF_EXP_MAX, HLF_QNAN_MANT};
      CLS_SUB:  s3_nxt = {s2_r.sign, 5'd0, s2_r.hman};
      CLS_NORM: begin
        // Mantissa carry bumps the exponent; 30 + 1 lands on infinity exactly
        if (man_inc[10]) begin
          s3_nxt = {s2_r.sign, exp_inc, 10'd0};
        end else begin
          s3_nxt = {s2_r.sign, s2_r.hexp, man_inc[9:0]};
        end
      end
      default:  s3_nxt = {s2_r.sign, 15'd0};
    endcase
  end

  // Advance valid bits; clear them on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Advance payloads; hold while the stage is stalled
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid     = v3_r;
  assign out_half_bits = s3_r;

endmodule
